// ===== hw/rtl/ipdc_pkg.sv =====
`default_nettype none

package ipdc_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int LIMIT_W  = 15;
    localparam int ERR_W    = SAMPLE_W + 1;
    localparam int GSUM_W   = GAIN_W + 2;
    localparam int PROD_W   = GSUM_W + 1 + ERR_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int FRAC_W   = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 16'd819;
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = 16'd2458;
    localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = 16'd0;
    localparam logic [LIMIT_W-1:0] DELTA_LIMIT_RST = 15'd102;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN   = 2'd0,
        REG_INTEG_GAIN  = 2'd1,
        REG_DERIV_GAIN  = 2'd2,
        REG_DELTA_LIMIT = 2'd3
    } t_cfg_reg;

    // Current error plus the two previous ones
    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [ERR_W-1:0] err1;
        logic signed [ERR_W-1:0] err2;
    } t_hist;

    // Gains and limit handed to the back end
    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [LIMIT_W-1:0] delta_limit;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hw/rtl/ipdc_front.sv =====
`default_nettype none

module ipdc_front import ipdc_pkg::*; (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_ready,
    input  wire signed [SAMPLE_W-1:0]  i_reference,
    input  wire signed [SAMPLE_W-1:0]  i_feedback,
    output logic                       o_push,
    output t_hist                      o_hist,
    input  wire                        i_push_ready
);

    logic signed [ERR_W-1:0] r_err1, n_err1;
    logic signed [ERR_W-1:0] r_err2, n_err2;
    logic signed [ERR_W-1:0] err;
    logic                    accept;

    // Error of the incoming request, exact in 17 bits
    assign err     = ERR_W'(i_reference) - ERR_W'(i_feedback);
    assign o_ready = i_push_ready;
    assign accept  = i_valid && i_push_ready;
    assign o_push  = accept;

    always_comb begin
        o_hist.err  = err;
        o_hist.err1 = r_err1;
        o_hist.err2 = r_err2;
    end

    // History shifts on every accepted request
    always_comb begin
        n_err1 = r_err1;
        n_err2 = r_err2;
        if (accept) begin
            n_err1 = err;
            n_err2 = r_err1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err1 <= '0;
            r_err2 <= '0;
        end else begin
            r_err1 <= n_err1;
            r_err2 <= n_err2;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ipdc_queue.sv =====
`default_nettype none

module ipdc_queue import ipdc_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    input  wire t_hist  i_push_data,
    output logic        o_push_ready,
    output logic        o_pop_valid,
    output t_hist       o_pop_data,
    input  wire         i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

    t_hist              r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_push, do_pop;

    assign o_push_ready = (r_count != FULL);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_slot[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    // Pointer wrap and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ipdc_back.sv =====
`default_nettype none

module ipdc_back import ipdc_pkg::*; (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire                        i_pop_valid,
    input  wire t_hist                 i_pop_data,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire                        i_ready,
    output logic signed [SAMPLE_W-1:0] o_drive_delta,
    output logic                       o_clipped
);

    logic                        en;
    logic [GSUM_W-1:0]           gain_a, gain_b;
    logic signed [PROD_W-1:0]    prod_a, prod_b, prod_c;

    logic                        r_m_valid, r_s_valid, r_o_valid;
    logic signed [PROD_W-1:0]    r_prod_a, r_prod_b, r_prod_c;
    logic signed [SUM_W-1:0]     r_sum, n_sum;
    logic signed [SAMPLE_W-1:0]  r_delta, n_delta;
    logic                        r_clip, n_clip;

    logic                        neg;
    logic [SUM_W-1:0]            mag;
    logic [SUM_W-1:0]            lim_wide;
    logic [SAMPLE_W-1:0]         res;

    // Whole pipeline moves when the output slot is free or being taken
    assign en      = !r_o_valid || i_ready;
    assign o_pop   = en && i_pop_valid;
    assign o_valid = r_o_valid;
    assign o_drive_delta = r_delta;
    assign o_clipped     = r_clip;

    // Combined gains: kp+ki+kd and kp+2kd
    assign gain_a = GSUM_W'(i_cfg.prop_gain) + GSUM_W'(i_cfg.integ_gain)
                  + GSUM_W'(i_cfg.deriv_gain);
    assign gain_b = GSUM_W'(i_cfg.prop_gain) + {1'b0, i_cfg.deriv_gain, 1'b0};

    // Stage M: three independent multiplies
    always_comb begin
        prod_a = $signed({1'b0, gain_a}) * i_pop_data.err;
        prod_b = $signed({1'b0, gain_b}) * i_pop_data.err1;
        prod_c = $signed({3'b000, i_cfg.deriv_gain}) * i_pop_data.err2;
    end

    // Stage S: exact sum
    assign n_sum = SUM_W'(r_prod_a) - SUM_W'(r_prod_b) + SUM_W'(r_prod_c);

    // Stage O: clamp on the exact value, else truncate magnitude toward zero
    always_comb begin
        neg      = r_sum[SUM_W-1];
        mag      = neg ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        lim_wide = {(SUM_W - LIMIT_W - FRAC_W)'(0), i_cfg.delta_limit, FRAC_W'(0)};
        n_clip   = (mag > lim_wide);
        res      = n_clip ? {1'b0, i_cfg.delta_limit} : mag[FRAC_W +: SAMPLE_W];
        n_delta  = neg ? $signed(-res) : $signed(res);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= i_pop_valid;
            r_s_valid <= r_m_valid;
            r_o_valid <= r_s_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod_a <= prod_a;
            r_prod_b <= prod_b;
            r_prod_c <= prod_c;
            r_sum    <= n_sum;
            r_delta  <= n_delta;
            r_clip   <= n_clip;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/incremental_pid_delta_clamp_core.sv =====
`default_nettype none

// Channel   Direction  Handshake                    Payload
// input     in         i_valid / o_ready            i_reference, i_feedback
// output    out        o_valid / i_ready            o_drive_delta, o_clipped
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One request per cycle sustained while the output is taken; a result passes
// through the queue, then the multiply, sum and clamp stages (the queue write
// happens at the accepting edge).
// The queue between front and back holds QUEUE_DEPTH requests, so input keeps
// flowing while the output is stalled until the queue and pipeline fill.
// Reset is synchronous: gains, limit and the error history return to their
// defaults, the queue and pipeline empty. Config writes are always taken.

module incremental_pid_delta_clamp_core import ipdc_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire signed [SAMPLE_W-1:0]    i_reference,
    input  wire signed [SAMPLE_W-1:0]    i_feedback,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic signed [SAMPLE_W-1:0]   o_drive_delta,
    output logic                         o_clipped,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]          i_cfg_index,
    input  wire [CFG_DATA_W-1:0]         i_cfg_data
);

    t_cfg   r_cfg, n_cfg;
    t_hist  push_data, pop_data;
    logic   push, push_ready, pop_valid, pop;

    // Config registers
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_PROP_GAIN:   n_cfg.prop_gain   = i_cfg_data;
                REG_INTEG_GAIN:  n_cfg.integ_gain  = i_cfg_data;
                REG_DERIV_GAIN:  n_cfg.deriv_gain  = i_cfg_data;
                REG_DELTA_LIMIT: n_cfg.delta_limit = i_cfg_data[LIMIT_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain   <= PROP_GAIN_RST;
            r_cfg.integ_gain  <= INTEG_GAIN_RST;
            r_cfg.deriv_gain  <= DERIV_GAIN_RST;
            r_cfg.delta_limit <= DELTA_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    ipdc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_reference  (i_reference),
        .i_feedback   (i_feedback),
        .o_push       (push),
        .o_hist       (push_data),
        .i_push_ready (push_ready)
    );

    ipdc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data),
        .i_pop        (pop)
    );

    ipdc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_pop_valid   (pop_valid),
        .i_pop_data    (pop_data),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_drive_delta (o_drive_delta),
        .o_clipped     (o_clipped)
    );

    // A clipped result sits exactly on the limit
    a_clip_on_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clipped) |->
            (o_drive_delta == $signed({1'b0, r_cfg.delta_limit}) ||
             o_drive_delta == -$signed({1'b0, r_cfg.delta_limit})))
        else $error("clipped result not at limit");

    // Any result stays within the limit
    a_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            ($signed(o_drive_delta) <= $signed({1'b0, r_cfg.delta_limit}) &&
             $signed(o_drive_delta) >= -$signed({1'b0, r_cfg.delta_limit})))
        else $error("result exceeds limit");

    // Nothing leaves the pipeline right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

// Tracks gains, limit and error history, and queues the expected delta per request
class pid_delta_tracker;
    logic [ipdc_pkg::GAIN_W-1:0]          kp, ki, kd;
    logic [ipdc_pkg::LIMIT_W-1:0]         limit;
    logic signed [ipdc_pkg::ERR_W-1:0]    err1, err2;
    logic signed [ipdc_pkg::SAMPLE_W-1:0] want_delta_q[$];
    logic                                 want_clip_q[$];
    int unsigned                          errors, checked, clips;

    function new();
        kp      = ipdc_pkg::PROP_GAIN_RST;
        ki      = ipdc_pkg::INTEG_GAIN_RST;
        kd      = ipdc_pkg::DERIV_GAIN_RST;
        limit   = ipdc_pkg::DELTA_LIMIT_RST;
        err1    = '0;
        err2    = '0;
        errors  = 0;
        checked = 0;
        clips   = 0;
    endfunction

    function void write_register(ipdc_pkg::t_cfg_reg idx,
                                 logic [ipdc_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            ipdc_pkg::REG_PROP_GAIN:   kp = data;
            ipdc_pkg::REG_INTEG_GAIN:  ki = data;
            ipdc_pkg::REG_DERIV_GAIN:  kd = data;
            ipdc_pkg::REG_DELTA_LIMIT: limit = data[ipdc_pkg::LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    // Velocity-form step: exact Q.12 sum, clip on the wide value, truncate toward zero
    function void note_request(logic signed [ipdc_pkg::SAMPLE_W-1:0] setpoint,
                               logic signed [ipdc_pkg::SAMPLE_W-1:0] measured);
        longint e, acc, bound, res;
        logic   clip;
        e     = longint'(setpoint) - longint'(measured);
        acc   = (longint'(kp) + longint'(ki) + longint'(kd)) * e
              - (longint'(kp) + 2 * longint'(kd)) * longint'(err1)
              + longint'(kd) * longint'(err2);
        bound = longint'(limit) <<< ipdc_pkg::FRAC_W;
        clip  = 1'b0;
        if (acc > bound) begin
            res  = longint'(limit);
            clip = 1'b1;
        end else if (acc < -bound) begin
            res  = -longint'(limit);
            clip = 1'b1;
        end else if (acc < 0) begin
            res = -((-acc) >>> ipdc_pkg::FRAC_W);
        end else begin
            res = acc >>> ipdc_pkg::FRAC_W;
        end
        err2 = err1;
        err1 = e[ipdc_pkg::ERR_W-1:0];
        want_delta_q.push_back(res[ipdc_pkg::SAMPLE_W-1:0]);
        want_clip_q.push_back(clip);
    endfunction

    function void check_result(logic signed [ipdc_pkg::SAMPLE_W-1:0] delta, logic clip);
        logic signed [ipdc_pkg::SAMPLE_W-1:0] want_d;
        logic                                 want_c;
        if (want_delta_q.size() == 0) begin
            $display("%0t: unexpected result drive_delta %0d clipped %0b", $time, delta, clip);
            errors++;
            return;
        end
        want_d = want_delta_q.pop_front();
        want_c = want_clip_q.pop_front();
        checked++;
        if (clip === 1'b1) clips++;
        if (delta !== want_d) begin
            $display("%0t: drive_delta expected %0d got %0d", $time, want_d, delta);
            errors++;
        end
        if (clip !== want_c) begin
            $display("%0t: clipped expected %0b got %0b", $time, want_c, clip);
            errors++;
        end
    endfunction

    function int pending();
        return want_delta_q.size();
    endfunction
endclass

module tb;
    import ipdc_pkg::*;

    localparam int SAMPLES_PER_SETTING = 100;
    localparam int HOLD_CYCLES         = 300;
    localparam int SETTLE_CYCLES       = 12;
    localparam int CYCLE_LIMIT         = 1000000;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_valid     = 1'b0;
    logic signed [SAMPLE_W-1:0]   i_reference = '0;
    logic signed [SAMPLE_W-1:0]   i_feedback  = '0;
    logic                         i_ready     = 1'b0;
    logic                         i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data  = '0;
    wire                          o_ready;
    wire                          o_valid;
    wire signed [SAMPLE_W-1:0]    o_drive_delta;
    wire                          o_clipped;
    wire                          o_cfg_ready;

    pid_delta_tracker tracker = new();

    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    int hold_orders    = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int cycle_count    = 0;
    int samples_sent   = 0;
    int settings_used  = 1;

    logic [SAMPLE_W-1:0] corners [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

    incremental_pid_delta_clamp_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_reference   (i_reference),
        .i_feedback    (i_feedback),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_drive_delta (o_drive_delta),
        .o_clipped     (o_clipped),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Result side: check accepted results, then pick ready for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) tracker.check_result(o_drive_delta, o_clipped);
        if (hold_orders != hold_served) begin
            hold_served = hold_orders;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("Verification failed");
        $finish;
    end

    // One request, then a random sender gap
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] setpoint,
                               input logic signed [SAMPLE_W-1:0] measured);
        i_valid     <= 1'b1;
        i_reference <= setpoint;
        i_feedback  <= measured;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_request(setpoint, measured);
        samples_sent++;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Wait until every expected result is in, then let the block settle
    task automatic drain();
        do @(posedge i_clk); while (tracker.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_register(idx, data);
    endtask

    // Reprogram all registers once the block is idle
    task automatic program_regs(input logic [CFG_DATA_W-1:0] kp, ki, kd, lim);
        i_valid <= 1'b0;
        drain();
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_DERIV_GAIN, kd);
        write_reg(REG_DELTA_LIMIT, lim);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(8192));
            default: return 16'($urandom);
        endcase
    endfunction

    // Limit data; bit 15 is random and must be dropped by the block
    function automatic logic [CFG_DATA_W-1:0] pick_limit();
        logic spare_bit;
        spare_bit = 1'($urandom_range(1));
        case ($urandom_range(3))
            0:       return {spare_bit, 15'h0000};
            1:       return {spare_bit, 15'h7FFF};
            2:       return {spare_bit, 15'($urandom_range(2048))};
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly a loop tracking its setpoint, some full-range noise and corners
    task automatic send_random_sample();
        logic signed [SAMPLE_W-1:0] sp, ms;
        int                         mode;
        mode = $urandom_range(9);
        sp   = 16'($urandom);
        if (mode < 6) begin
            ms = sp + 16'($urandom_range(1024)) - 16'd512;
        end else if (mode < 8) begin
            ms = 16'($urandom);
        end else begin
            sp = corners[2'($urandom_range(3))];
            ms = corners[2'($urandom_range(3))];
        end
        send_sample(sp, ms);
    endtask

    initial begin
        int phase, seg, n;
        repeat (10) @(posedge i_clk);
        i_rst_n     <= 1'b1;
        tx_idle_pct = 18;
        rx_idle_pct = 64;

        // Reset gains: zero, full-scale errors of both signs, equal samples
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh0001, 16'sh0000);
        send_sample(16'sh0000, 16'sh0001);
        send_sample(16'sh7FFF, 16'sh7FFF);

        // Full-scale gains, widest limit (bit 15 of the data dropped)
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'sh0064, 16'shFF9C);

        // Half gain: odd error steps land on a half, truncated toward zero
        program_regs(16'h0800, 16'h0000, 16'h0000, 16'h7FFF);
        send_sample(16'sh0000, 16'sh0001);
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'sh0000, 16'sh0003);
        send_sample(16'sh0003, 16'sh0000);

        // Zero limit: only an exact zero sum escapes the clip
        program_regs(16'h1000, 16'h0000, 16'h1000, 16'h8000);
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'sh0001, 16'sh0000);
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'shFFFF, 16'sh0000);

        // Random part: three idle profiles, four settings each
        for (phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 64 : 0;
            rx_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 18 : 0;
            for (seg = 0; seg < 4; seg++) begin
                program_regs(pick_gain(), pick_gain(), pick_gain(), pick_limit());
                for (n = 0; n < SAMPLES_PER_SETTING; n++) begin
                    // long output stall while requests keep coming
                    if (seg == 1 && n == 30) hold_orders++;
                    // sender waits for the block to empty
                    if (seg == 2 && n == 50) begin
                        i_valid <= 1'b0;
                        drain();
                    end
                    send_random_sample();
                end
            end
        end

        i_valid <= 1'b0;
        drain();
        $display("Ran %0d samples under %0d gain/limit settings with idle and stall mixes.",
                 samples_sent, settings_used);
        $display("%0d results checked, %0d clipped, %0d mismatches.",
                 tracker.checked, tracker.clips, tracker.errors);
        if (tracker.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
